FILE: hdl/lagi_pkg.sv
// ---------------------------------------------------------------------------
// lagi_pkg: shared types and constants for the Lagrange interpolator
// Q16.16 formats, node count, and the command/status structs that run
// between the controller and the datapath.
// ---------------------------------------------------------------------------
package lagi_pkg;

	localparam int NODES = 8;
	localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int IN_IDX_W = 3;

	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_COIN = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	// multiplier operand select
	typedef enum logic [1:0] {
		MS_NUM,   // num_q * (x - xj)
		MS_DEN,   // den_q * (xi - xj)
		MS_TERM   // q * yi
	} mul_sel_t;

	typedef struct packed {
		logic             clear;      // start evaluation: reset acc, sat
		logic             init_prod;  // num/den := 1.0
		logic             mul_go;     // load multiplier stage
		mul_sel_t         mul_sel;
		logic             mul_wb;     // write multiplier result back
		logic             div_start;
		logic             acc_add;    // add term to accumulator
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
	} lagi_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic den_zero;
	} lagi_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v,
		output logic sat);
		begin
			sat = 1'b0;
			if (v > 64'sd2147483647) begin
				sat = 1'b1;
				sat32 = S32_MAX;
			end else if (v < -64'sd2147483648) begin
				sat = 1'b1;
				sat32 = S32_MIN;
			end else begin
				sat32 = v[31:0];
			end
		end
	endfunction

endpackage

FILE: hdl/lagi_div.sv
// ---------------------------------------------------------------------------
// lagi_div: signed 48/32 radix-2 divider
// Computes (num * 2^16) / den truncated toward zero, saturated to 32 bits.
// One quotient bit per cycle.
// ---------------------------------------------------------------------------
module lagi_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [31:0]  num,
	input  logic signed [31:0]  den,
	output logic                busy,
	output logic signed [31:0]  quo,
	output logic                sat
);
	import lagi_pkg::*;

	localparam int QW = 48;

	logic [QW-1:0] dvd_q;
	logic [32:0]   rem_q;
	logic [31:0]   dvs_q;
	logic          neg_q;
	logic [5:0]    cnt_q;
	logic [33:0]   trial;
	logic [32:0]   shifted;
	logic [QW:0]   mag;
	logic signed [63:0] sq;

	assign shifted = {rem_q[31:0], dvd_q[QW-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= 6'(QW);
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1)
				busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {(num[31] ? 32'(-num) : 32'(num)), 16'h0};
			dvs_q <= den[31] ? 32'(-den) : 32'(den);
			neg_q <= num[31] ^ den[31];
			rem_q <= '0;
		end else if (busy) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				dvd_q <= {dvd_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				dvd_q <= {dvd_q[QW-2:0], 1'b0};
			end
		end
	end

	// dvd_q holds the quotient magnitude once done
	always_comb begin
		mag = {1'b0, dvd_q};
		sq  = neg_q ? -64'(mag) : 64'(mag);
		quo = sat32(sq, sat);
	end

endmodule

FILE: hdl/lagi_datapath.sv
// ---------------------------------------------------------------------------
// lagi_datapath: node store, shared multiplier, divider and accumulator
// One 32x32 multiply per command, registered, then truncate/saturate.
// ---------------------------------------------------------------------------
module lagi_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     ld_en,
	input  logic [lagi_pkg::IN_IDX_W-1:0] ld_idx,
	input  logic signed [31:0]       ld_x,
	input  logic signed [31:0]       ld_y,
	input  logic signed [31:0]       eval_x,
	input  lagi_pkg::lagi_cmd_t      cmd,
	output lagi_pkg::lagi_sts_t      sts,
	output logic signed [31:0]       value,
	output logic                     sat_any
);
	import lagi_pkg::*;

	logic signed [31:0] xs_q [NODES];
	logic signed [31:0] ys_q [NODES];
	logic signed [31:0] num_q, den_q, q_q;
	logic signed [35:0] acc_q;
	logic               sat_q;
	logic signed [31:0] ma_s1, mb_s1;
	logic signed [63:0] prod_s2;
	mul_sel_t           sel_s1;
	logic               go_s1;
	logic signed [32:0] dnum, dden;
	logic               s_dn, s_dd, s_p, s_acc;
	logic signed [31:0] cn, cd, pr, dq;
	logic signed [63:0] pshift;
	logic               dbusy, dsat, busy_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NODES; k++) begin
				xs_q[k] <= '0;
				ys_q[k] <= '0;
			end
		end else if (ld_en && 32'(ld_idx) < NODES) begin
			xs_q[IDX_W'(ld_idx)] <= ld_x;
			ys_q[IDX_W'(ld_idx)] <= ld_y;
		end
	end

	assign dnum = 33'(eval_x) - 33'(xs_q[cmd.j]);
	assign dden = 33'(xs_q[cmd.i]) - 33'(xs_q[cmd.j]);
	assign pshift = prod_s2 >>> 16;

	always_comb begin
		cn    = sat32(64'(dnum), s_dn);
		cd    = sat32(64'(dden), s_dd);
		pr    = sat32(pshift, s_p);
		value = sat32(64'(acc_q), s_acc);
	end

	lagi_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(num_q), .den(den_q), .busy(dbusy), .quo(dq), .sat(dsat)
	);

	always_ff @(posedge clk) begin
		go_s1 <= cmd.mul_go;
		busy_d_q <= dbusy;
		if (cmd.mul_go) begin
			sel_s1 <= cmd.mul_sel;
			unique case (cmd.mul_sel)
				MS_NUM:  begin ma_s1 <= num_q; mb_s1 <= cn; end
				MS_DEN:  begin ma_s1 <= den_q; mb_s1 <= cd; end
				default: begin ma_s1 <= q_q;   mb_s1 <= ys_q[cmd.i]; end
			endcase
		end
		if (go_s1)
			prod_s2 <= ma_s1 * mb_s1;
		if (cmd.init_prod) begin
			num_q <= ONE_Q16;
			den_q <= ONE_Q16;
		end else if (cmd.mul_wb) begin
			if (sel_s1 == MS_NUM)
				num_q <= pr;
			else if (sel_s1 == MS_DEN)
				den_q <= pr;
		end
		if (busy_d_q && !dbusy)
			q_q <= dq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.clear) begin
			acc_q <= '0;
			sat_q <= 1'b0;
		end else begin
			if (cmd.mul_go && cmd.mul_sel == MS_NUM && s_dn)
				sat_q <= 1'b1;
			if (cmd.mul_go && cmd.mul_sel == MS_DEN && s_dd)
				sat_q <= 1'b1;
			// product saturation is flagged on the write-back and accumulate steps
			if ((cmd.mul_wb || cmd.acc_add) && s_p)
				sat_q <= 1'b1;
			if (busy_d_q && !dbusy && dsat)
				sat_q <= 1'b1;
			if (cmd.acc_add)
				acc_q <= acc_q + 36'(pr);
		end
	end

	assign sat_any = sat_q | s_acc;
	assign sts.div_busy = dbusy | cmd.div_start;
	assign sts.den_zero = (den_q == '0);

endmodule

FILE: hdl/lagi_ctrl.sv
// ---------------------------------------------------------------------------
// lagi_ctrl: evaluation sequencer
// Walks node i, inner node j, issues multiply, divide and accumulate steps.
// ---------------------------------------------------------------------------
module lagi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                out_free,
	input  lagi_pkg::lagi_sts_t sts,
	output lagi_pkg::lagi_cmd_t cmd,
	output logic                busy,
	output logic                done,
	output logic                coin
);
	import lagi_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_NMUL, S_NWAIT, S_NWB, S_DMUL, S_DWAIT, S_DWB,
		S_CHK, S_DIV, S_DIVW, S_TMUL, S_TWAIT, S_TACC, S_DONE
	} state_t;

	state_t           st_q;
	logic [IDX_W-1:0] i_q, j_q;

	localparam logic [IDX_W-1:0] LAST = IDX_W'(NODES - 1);

	always_comb begin
		cmd = '0;
		cmd.i = i_q;
		cmd.j = j_q;
		cmd.mul_sel = MS_NUM;
		unique case (st_q)
			S_IDLE:  cmd.clear = start;
			S_INIT:  cmd.init_prod = 1'b1;
			S_NMUL:  cmd.mul_go = 1'b1;
			S_NWB:   cmd.mul_wb = 1'b1;
			S_DMUL:  begin cmd.mul_go = 1'b1; cmd.mul_sel = MS_DEN; end
			S_DWB:   cmd.mul_wb = 1'b1;
			S_DIV:   cmd.div_start = 1'b1;
			S_TMUL:  begin cmd.mul_go = 1'b1; cmd.mul_sel = MS_TERM; end
			S_TACC:  cmd.acc_add = 1'b1;
			default: ;
		endcase
	end

	assign busy = (st_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			i_q  <= '0;
			j_q  <= '0;
			done <= 1'b0;
			coin <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				S_IDLE: if (start) begin
					i_q  <= '0;
					st_q <= S_INIT;
				end
				S_INIT: begin
					j_q  <= (i_q == '0) ? IDX_W'(1) : '0;
					st_q <= S_NMUL;
				end
				S_NMUL:  st_q <= S_NWAIT;
				S_NWAIT: st_q <= S_NWB;
				S_NWB:   st_q <= S_DMUL;
				S_DMUL:  st_q <= S_DWAIT;
				S_DWAIT: st_q <= S_DWB;
				S_DWB: begin
					if (j_q == LAST || (j_q + IDX_W'(1) == i_q && i_q == LAST))
						st_q <= S_CHK;
					else begin
						j_q  <= (j_q + IDX_W'(1) == i_q) ? j_q + IDX_W'(2)
							: j_q + IDX_W'(1);
						st_q <= S_NMUL;
					end
				end
				S_CHK: if (sts.den_zero) begin
					coin <= 1'b1;
					st_q <= S_DONE;
				end else begin
					st_q <= S_DIV;
				end
				S_DIV:   st_q <= S_DIVW;
				S_DIVW:  if (!sts.div_busy) st_q <= S_TMUL;
				S_TMUL:  st_q <= S_TWAIT;
				S_TWAIT: st_q <= S_TACC;
				S_TACC: begin
					coin <= 1'b0;
					if (i_q == LAST)
						st_q <= S_DONE;
					else begin
						i_q  <= i_q + IDX_W'(1);
						st_q <= S_INIT;
					end
				end
				S_DONE: if (out_free) begin
					done <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/lagrange_interpolator.sv
// ---------------------------------------------------------------------------
// lagrange_interpolator: Q16.16 Lagrange polynomial evaluation over 8 nodes
//
// channel  dir  tdata fields (low bit up)                         tuser
// s_axis   in   node_index[2:0] node_x[34:3] node_y[66:35]       operation
//                eval_x[98:67], zero pad to 104 bits
// m_axis   out  value[31:0]                                      status[1:0]
//
// A load writes the node store as it is accepted. An evaluation steps
// through a numerator and a denominator multiply per inner node, and per
// outer node a setup, a zero check, a divide wait, a term multiply and
// accumulate; its length is set by the shared multiplier and the serial
// divider. One item is in work at a time; s_tready is low while evaluating.
// Results sit in an output register; a stalled m_axis holds the sequencer
// before it finishes. Reset clears all nodes to zero.
// ---------------------------------------------------------------------------
module lagrange_interpolator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,  // node_index, node_x, node_y, eval_x
	input  logic         s_tuser,  // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,  // value
	output logic [1:0]   m_tuser   // status
);
	import lagi_pkg::*;

	lagi_cmd_t cmd;
	lagi_sts_t sts;
	logic      acc_in, busy, done, coin, sat_any, out_free;
	logic signed [31:0] value, ex_q;

	assign s_tready = !busy;
	assign acc_in   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk)
		if (acc_in && s_tuser == OP_EVAL)
			ex_q <= s_tdata[98:67];

	lagi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(acc_in && s_tuser == OP_EVAL),
		.out_free(out_free), .sts(sts), .cmd(cmd), .busy(busy),
		.done(done), .coin(coin)
	);

	lagi_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ld_en(acc_in && s_tuser == OP_LOAD),
		.ld_idx(s_tdata[2:0]), .ld_x(s_tdata[34:3]), .ld_y(s_tdata[66:35]),
		.eval_x(ex_q), .cmd(cmd), .sts(sts), .value(value), .sat_any(sat_any)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			if (done)
				m_tvalid <= 1'b1;
		end
	end

	always_ff @(posedge clk)
		if (done) begin
			m_tdata <= coin ? 32'h0 : value;
			m_tuser <= coin ? ST_COIN : (sat_any ? ST_SAT : ST_OK);
		end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready) else $error("accepted while busy");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(out_free)) else $error("result overwrote pending");
	a_coin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_COIN) |-> m_tdata == 32'h0)
		else $error("coincident result not zero");

endmodule
